>>> rtl/skvt_pkg.sv
package skvt_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned POS_W = 7;
  localparam int unsigned CNT_W = 8;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_FIND = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

>>> rtl/skvt_mem.sv
module skvt_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 128
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/skvt_cmp.sv
module skvt_cmp
  import skvt_pkg::*;
(
  input  logic [KEY_W-1:0] a_i,
  input  logic [KEY_W-1:0] b_i,
  output cmp_res_t         res_o
);

  // unsigned order of packed names matches string order
  always_comb begin
    res_o.eq = (a_i == b_i);
    res_o.gt = (a_i > b_i);
  end

endmodule

>>> rtl/sorted_key_value_table.sv
// sorted key/value table, one command at a time over a key/value memory with one write and one read port
// a full table, an unknown command or an empty table goes straight to the response state;
// otherwise add/find/delete compare or shift one memory entry per cycle
// a new command is taken only once the last is done; input stalls until the result is registered
// reset (async, active low) empties the table; memory contents are not cleared
module sorted_key_value_table
  import skvt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       command_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [VAL_W-1:0] found_value_o,
  output logic [POS_W-1:0] position_o,
  output logic [CNT_W-1:0] entry_count_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW = KEY_W + VAL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CMP,
    S_ADD_PUT,
    S_SCAN,
    S_DEL_SH,
    S_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    count_q, count_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [1:0]       res_status_q, res_status_d;
  logic [VAL_W-1:0] res_value_q, res_value_d;
  logic [IW-1:0]    res_pos_q, res_pos_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;
  logic [POS_W-1:0] out_pos_q, out_pos_d;
  logic [CNT_W-1:0] out_count_q, out_count_d;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  cmp_res_t      cmp_res;

  skvt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  skvt_cmp u_cmp (
    .a_i   (mem_rdata[DW-1:VAL_W]),
    .b_i   (key_q),
    .res_o (cmp_res)
  );

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_pos_d    = res_pos_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = command_i;
          key_d        = key_i;
          val_d        = value_i;
          res_value_d  = '0;
          res_pos_d    = '0;
          res_status_d = ST_NOT_FOUND;
          case (command_i)
            CMD_ADD: begin
              if (count_q >= CW'(TABLE_DEPTH)) begin
                res_status_d = ST_FULL;
                state_d      = S_RESP;
              end else if (count_q == '0) begin
                mem_we       = 1'b1;
                mem_waddr    = '0;
                mem_wdata    = {key_i, value_i};
                count_d      = count_q + CW'(1);
                res_status_d = ST_OK;
                state_d      = S_RESP;
              end else begin
                idx_d     = IW'(count_q);
                mem_re    = 1'b1;
                mem_raddr = IW'(count_q - CW'(1));
                state_d   = S_ADD_CMP;
              end
            end
            CMD_FIND, CMD_DEL: begin
              if (count_q == '0) begin
                state_d = S_RESP;
              end else begin
                idx_d     = '0;
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = S_SCAN;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // entry idx-1 is on the read port; shift it up while its key is larger
      S_ADD_CMP: begin
        if (cmp_res.gt) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = mem_rdata;
          idx_d     = idx_q - IW'(1);
          if (idx_q != IW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = idx_q - IW'(2);
          end else begin
            state_d = S_ADD_PUT;
          end
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = idx_q;
          mem_wdata    = {key_q, val_q};
          count_d      = count_q + CW'(1);
          res_status_d = ST_OK;
          res_pos_d    = idx_q;
          state_d      = S_RESP;
        end
      end

      S_ADD_PUT: begin
        mem_we       = 1'b1;
        mem_waddr    = '0;
        mem_wdata    = {key_q, val_q};
        count_d      = count_q + CW'(1);
        res_status_d = ST_OK;
        res_pos_d    = '0;
        state_d      = S_RESP;
      end

      // entry idx is on the read port
      S_SCAN: begin
        if (cmp_res.eq) begin
          res_status_d = ST_OK;
          res_pos_d    = idx_q;
          if (cmd_q == CMD_FIND) begin
            res_value_d = mem_rdata[VAL_W-1:0];
            state_d     = S_RESP;
          end else if (CW'(idx_q) + CW'(1) < count_q) begin
            mem_re    = 1'b1;
            mem_raddr = idx_q + IW'(1);
            state_d   = S_DEL_SH;
          end else begin
            count_d = count_q - CW'(1);
            state_d = S_RESP;
          end
        end else if (CW'(idx_q) + CW'(1) < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + IW'(1);
          idx_d     = idx_q + IW'(1);
        end else begin
          state_d = S_RESP;
        end
      end

      // entry idx+1 is on the read port; move it down into the gap
      S_DEL_SH: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = mem_rdata;
        idx_d     = idx_q + IW'(1);
        if (CW'(idx_q) + CW'(2) < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + IW'(2);
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_pos_d    = POS_W'(res_pos_q);
          out_count_d  = CNT_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      count_q      <= '0;
      cmd_q        <= CMD_ADD;
      key_q        <= '0;
      val_q        <= '0;
      res_status_q <= ST_OK;
      res_value_q  <= '0;
      res_pos_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_value_q  <= '0;
      out_pos_q    <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      cmd_q        <= cmd_d;
      key_q        <= key_d;
      val_q        <= val_d;
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      res_pos_q    <= res_pos_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_pos_q    <= out_pos_d;
      out_count_q  <= out_count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_value_q;
  assign position_o    = out_pos_q;
  assign entry_count_o = out_count_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import skvt_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 128;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // code three carries no operation
  localparam logic [1:0]  CMD_NONE       = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] entry_count;
  } table_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       command_i;
  logic [KEY_W-1:0] key_i;
  logic [VAL_W-1:0] value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [1:0]       status_o;
  logic [VAL_W-1:0] found_value_o;
  logic [POS_W-1:0] position_o;
  logic [CNT_W-1:0] entry_count_o;

  // table contents as the block should hold them
  logic [KEY_W-1:0] tbl_keys [TABLE_DEPTH];
  logic [VAL_W-1:0] tbl_vals [TABLE_DEPTH];
  int unsigned      tbl_count;

  table_result_t    expected_results [$];
  int unsigned      error_count;
  int unsigned      idle_cycles;
  logic [KEY_W-1:0] key_pool [32];
  bit               tx_quiet;
  bit               rx_quiet;
  int unsigned      stall_left;

  sorted_key_value_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic table_result_t apply_command(logic [1:0] cmd, logic [KEY_W-1:0] k,
                                                  logic [VAL_W-1:0] v);
    table_result_t res;
    int unsigned   i;
    res = '{status: ST_NOT_FOUND, found_value: '0, position: '0, entry_count: '0};
    case (cmd)
      CMD_ADD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // shift larger keys up, new pair lands after any equal keys
          i = tbl_count;
          while (i > 0 && tbl_keys[i-1] > k) begin
            tbl_keys[i] = tbl_keys[i-1];
            tbl_vals[i] = tbl_vals[i-1];
            i--;
          end
          tbl_keys[i] = k;
          tbl_vals[i] = v;
          tbl_count++;
          res.status   = ST_OK;
          res.position = i[POS_W-1:0];
        end
      end
      CMD_FIND, CMD_DEL: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_keys[i] == k) break;
        end
        if (i < tbl_count) begin
          res.status   = ST_OK;
          res.position = i[POS_W-1:0];
          if (cmd == CMD_FIND) begin
            res.found_value = tbl_vals[i];
          end else begin
            for (int unsigned j = i; j + 1 < tbl_count; j++) begin
              tbl_keys[j] = tbl_keys[j+1];
              tbl_vals[j] = tbl_vals[j+1];
            end
            tbl_count--;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = tbl_count[CNT_W-1:0];
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pack_name(string s);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      k = {k[KEY_W-9:0], (i < s.len()) ? 8'(s[i]) : 8'h00};
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] random_name();
    logic [KEY_W-1:0] k;
    int unsigned      len;
    k   = '0;
    len = $urandom_range(1, 8);
    for (int unsigned i = 0; i < 8; i++) begin
      k = {k[KEY_W-9:0], (i < len) ? 8'($urandom_range(8'h20, 8'h7e)) : 8'h00};
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] random_wide();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void refill_pool();
    int unsigned r;
    for (int i = 0; i < 32; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) key_pool[i] = '0;
      else if (r == 1) key_pool[i] = '1;
      else if (r < 12) key_pool[i] = random_name();
      else key_pool[i] = random_wide();
    end
  endfunction

  // mostly keys that repeat or are stored, so finds and deletes hit
  function automatic logic [KEY_W-1:0] pick_key(int unsigned pool_len);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return key_pool[$urandom_range(0, pool_len - 1)];
    if (r < 70 && tbl_count > 0) return tbl_keys[$urandom_range(0, tbl_count - 1)];
    if (r < 85) return random_name();
    return random_wide();
  endfunction

  task automatic send_command(logic [1:0] cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int unsigned gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_i      <= k;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(apply_command(cmd, k, v));
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_basic_ops();
    logic [KEY_W-1:0] bob;
    logic [KEY_W-1:0] alice;
    bob   = pack_name("bob");
    alice = pack_name("alice");
    // empty table
    send_command(CMD_FIND, '0, '0);
    send_command(CMD_DEL, '1, '1);
    send_command(CMD_NONE, '1, '1);
    // extremes, and an equal key sitting in the first entry
    send_command(CMD_ADD, '0, '1);
    send_command(CMD_ADD, '1, '0);
    send_command(CMD_ADD, '0, 64'd1);
    send_command(CMD_ADD, bob, random_wide());
    send_command(CMD_ADD, alice, random_wide());
    send_command(CMD_FIND, '0, random_wide());
    send_command(CMD_FIND, '1, '0);
    send_command(CMD_FIND, pack_name("carol"), '0);
    send_command(CMD_DEL, '0, '0);
    send_command(CMD_FIND, '0, '0);
    send_command(CMD_DEL, pack_name("carol"), '0);
    send_command(CMD_NONE, bob, '1);
    send_command(CMD_ADD, bob, random_wide());
    send_command(CMD_FIND, bob, '0);
    send_command(CMD_DEL, '1, '0);
    send_command(CMD_DEL, bob, '0);
    send_command(CMD_FIND, bob, '0);
    send_command(CMD_DEL, bob, '0);
    send_command(CMD_DEL, alice, '0);
    send_command(CMD_DEL, '0, '0);
    send_command(CMD_FIND, alice, '0);
  endtask

  task automatic test_fill_and_full();
    // printable names stay below the all-ones key, which then lands at the top slot
    while (tbl_count < TABLE_DEPTH - 1) begin
      send_command(CMD_ADD, random_name(), random_wide());
    end
    send_command(CMD_ADD, '1, random_wide());
    send_command(CMD_ADD, '0, random_wide());
    send_command(CMD_ADD, '1, random_wide());
    send_command(CMD_FIND, '1, '0);
    send_command(CMD_FIND, tbl_keys[0], '0);
    send_command(CMD_DEL, tbl_keys[TABLE_DEPTH / 2], '0);
    send_command(CMD_ADD, '0, random_wide());
    send_command(CMD_ADD, random_name(), random_wide());
    while (tbl_count > 0) begin
      send_command(CMD_DEL, tbl_keys[$urandom_range(0, tbl_count - 1)], '0);
    end
    send_command(CMD_FIND, '1, '0);
    send_command(CMD_DEL, '0, '0);
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned add_pct,
                                     int unsigned pool_len);
    int unsigned r;
    logic [1:0]  cmd;
    refill_pool();
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) cmd = CMD_NONE;
      else if (r < 2 + add_pct) cmd = CMD_ADD;
      else if ($urandom_range(0, 1) == 1) cmd = CMD_FIND;
      else cmd = CMD_DEL;
      send_command(cmd, pick_key(pool_len), random_wide());
      if ($urandom_range(0, 99) == 0) refill_pool();
    end
  endtask

  // receiver stalls
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!rx_quiet && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (found_value_o !== want.found_value) begin
          $error("found_value: expected %h, got %h", want.found_value, found_value_o);
          error_count++;
        end
        if (position_o !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position_o);
          error_count++;
        end
        if (entry_count_o !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAIL sorted_key_value_table");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    command_i   = CMD_ADD;
    key_i       = '0;
    value_i     = '0;
    tbl_count   = 0;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    refill_pool();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops();
    wait_for_results();
    test_fill_and_full();
    test_random_traffic(250, 60, 16);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    test_random_traffic(200, 45, 4);
    wait_for_results();
    tx_quiet = 1'b0;
    test_random_traffic(150, 30, 8);
    rx_quiet = 1'b0;
    test_random_traffic(200, 20, 8);
    test_random_traffic(200, 50, 32);

    wait_for_results();
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS sorted_key_value_table");
    end else begin
      $display("FAIL sorted_key_value_table");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/skvt_pkg.sv
rtl/skvt_mem.sv
rtl/skvt_cmp.sv
rtl/sorted_key_value_table.sv
tb/testbench.sv
